>>> sv/owtr_pkg.sv
package owtr_pkg;

   // Configuration register indexes, in address order.
   localparam int NUM_REGS = 7;
   localparam int REG_IDX_W = $clog2(NUM_REGS);

   localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SLOT_START    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_READ_RECOVER  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CONVERT_WAIT  = 3'd6;

   localparam int DUR_W = 16;

   // All duration registers, entry i is register i.
   typedef logic [NUM_REGS-1:0][DUR_W-1:0] cfg_type;

   localparam cfg_type CFG_RESET = {16'd100, 16'd120, 16'd8, 16'd60, 16'd2, 16'd500, 16'd500};

   // Bus drive codes.
   localparam logic [1:0] DRIVE_RELEASE = 2'd0;
   localparam logic [1:0] DRIVE_LOW     = 2'd1;
   localparam logic [1:0] DRIVE_HIGH    = 2'd2;

   // One result, packed with bus_drive in the lowest bits.
   typedef struct packed {
      logic signed [15:0] temperature;
      logic               done_res;
      logic               busy_res;
      logic [1:0]         bus_drive;
   } rsp_type;

endpackage

>>> sv/owtr_seq.sv
module owtr_seq #(
   parameter int READ_BITS = 16,
   parameter int COUNTER_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              start_req,
   input  logic              line_level,
   input  owtr_pkg::cfg_type cfg,
   output owtr_pkg::rsp_type res
);
   import owtr_pkg::*;

   localparam int BIT_W = $clog2(READ_BITS);
   localparam int CMP_W = (COUNTER_WIDTH + 1 > DUR_W) ? COUNTER_WIDTH + 1 : DUR_W;
   localparam logic [CMP_W-1:0] LIM = CMP_W'(1) << COUNTER_WIDTH;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RST1  = 4'd1;
   localparam logic [3:0] ST_SKIP1 = 4'd2;
   localparam logic [3:0] ST_CONV  = 4'd3;
   localparam logic [3:0] ST_WAIT  = 4'd4;
   localparam logic [3:0] ST_RST2  = 4'd5;
   localparam logic [3:0] ST_SKIP2 = 4'd6;
   localparam logic [3:0] ST_RDCMD = 4'd7;
   localparam logic [3:0] ST_READ  = 4'd8;

   localparam logic [1:0] PH_OPEN   = 2'd0;
   localparam logic [1:0] PH_MIDDLE = 2'd1;
   localparam logic [1:0] PH_LATE   = 2'd2;

   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_SP  = 8'hBE;

   logic [3:0]               step_ff, step_in;
   logic [1:0]               phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0] tick_ff, tick_in, tick_next;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic [7:0]               cmd_ff, cmd_in;
   logic [READ_BITS-1:0]     rshift_ff, rshift_in;
   logic signed [15:0]       temp_ff, temp_in;

   logic [3:0]           cur_step;
   logic [REG_IDX_W-1:0] dur_sel;
   logic [DUR_W-1:0]     dur_raw;
   logic [CMP_W-1:0]     dur_ext, dur_eff, tick_inc;
   logic                 phase_end;
   logic [1:0]           drive;
   logic                 done;

   // A start while idle makes this tick the first tick of the first reset pulse.
   // Phase, tick and bit counters are already zero whenever the sequencer is idle.
   assign cur_step = (step_ff == ST_IDLE && start_req) ? ST_RST1 : step_ff;

   always_comb begin
      dur_sel = REG_SLOT_START;
      unique case (cur_step)
         ST_RST1, ST_RST2: begin
            dur_sel = (phase_ff == PH_OPEN) ? REG_RESET_LOW : REG_RESET_RELEASE;
         end
         ST_SKIP1, ST_CONV, ST_SKIP2, ST_RDCMD: begin
            dur_sel = (phase_ff == PH_OPEN) ? REG_SLOT_START : REG_WRITE_HOLD;
         end
         ST_WAIT: begin
            dur_sel = REG_CONVERT_WAIT;
         end
         ST_READ: begin
            priority case (phase_ff)
               PH_OPEN:   dur_sel = REG_SLOT_START;
               PH_MIDDLE: dur_sel = REG_READ_SAMPLE;
               default:   dur_sel = REG_READ_RECOVER;
            endcase
         end
         default: begin
            dur_sel = REG_SLOT_START;
         end
      endcase
   end

   // A zero duration counts as one tick; a duration beyond the counter range is clipped.
   assign dur_raw  = cfg[dur_sel];
   assign dur_ext  = CMP_W'(dur_raw);
   assign tick_inc = CMP_W'(tick_ff) + CMP_W'(1);

   always_comb begin
      if (dur_raw == '0) begin
         dur_eff = CMP_W'(1);
      end else if (dur_ext > LIM) begin
         dur_eff = LIM;
      end else begin
         dur_eff = dur_ext;
      end
   end

   assign phase_end = (tick_inc >= dur_eff);
   assign tick_next = phase_end ? '0 : tick_ff + COUNTER_WIDTH'(1);

   always_comb begin
      step_in   = cur_step;
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      cmd_in    = cmd_ff;
      rshift_in = rshift_ff;
      temp_in   = temp_ff;
      drive     = DRIVE_RELEASE;
      done      = 1'b0;

      unique case (cur_step)
         ST_IDLE: begin
         end
         ST_RST1, ST_RST2: begin
            if (phase_ff == PH_OPEN) begin
               drive   = DRIVE_LOW;
               tick_in = tick_next;
               if (phase_end) begin
                  phase_in = PH_MIDDLE;
               end
            end else if (phase_ff == PH_MIDDLE) begin
               tick_in = tick_next;
               if (phase_end) begin
                  step_in  = (cur_step == ST_RST1) ? ST_SKIP1 : ST_SKIP2;
                  phase_in = PH_OPEN;
                  bit_in   = '0;
                  cmd_in   = CMD_SKIP_ROM;
               end
            end else begin
               step_in  = ST_IDLE;
               phase_in = PH_OPEN;
               tick_in  = '0;
               bit_in   = '0;
            end
         end
         ST_SKIP1, ST_CONV, ST_SKIP2, ST_RDCMD: begin
            if (phase_ff == PH_OPEN) begin
               drive   = DRIVE_LOW;
               tick_in = tick_next;
               if (phase_end) begin
                  phase_in = PH_MIDDLE;
               end
            end else if (phase_ff == PH_MIDDLE) begin
               drive   = cmd_ff[0] ? DRIVE_HIGH : DRIVE_LOW;
               tick_in = tick_next;
               if (phase_end) begin
                  cmd_in   = {1'b0, cmd_ff[7:1]};
                  phase_in = PH_OPEN;
                  if (bit_ff >= BIT_W'(7)) begin
                     bit_in = '0;
                     priority case (cur_step)
                        ST_SKIP1: begin
                           step_in = ST_CONV;
                           cmd_in  = CMD_CONVERT;
                        end
                        ST_CONV: begin
                           step_in = ST_WAIT;
                        end
                        ST_SKIP2: begin
                           step_in = ST_RDCMD;
                           cmd_in  = CMD_READ_SP;
                        end
                        default: begin
                           step_in   = ST_READ;
                           rshift_in = '0;
                        end
                     endcase
                  end else begin
                     bit_in = bit_ff + BIT_W'(1);
                  end
               end
            end else begin
               step_in  = ST_IDLE;
               phase_in = PH_OPEN;
               tick_in  = '0;
               bit_in   = '0;
            end
         end
         ST_WAIT: begin
            tick_in = tick_next;
            if (phase_end) begin
               step_in  = ST_RST2;
               phase_in = PH_OPEN;
               bit_in   = '0;
            end
         end
         ST_READ: begin
            if (phase_ff == PH_OPEN) begin
               drive   = DRIVE_LOW;
               tick_in = tick_next;
               if (phase_end) begin
                  phase_in = PH_MIDDLE;
               end
            end else if (phase_ff == PH_MIDDLE) begin
               tick_in = tick_next;
               if (phase_end) begin
                  // The bus level on the last released tick is the data bit, LSB first.
                  rshift_in = {line_level, rshift_ff[READ_BITS-1:1]};
                  phase_in  = PH_LATE;
               end
            end else if (phase_ff == PH_LATE) begin
               tick_in = tick_next;
               if (phase_end) begin
                  if (bit_ff >= BIT_W'(READ_BITS - 1)) begin
                     temp_in  = 16'($signed(rshift_ff));
                     done     = 1'b1;
                     step_in  = ST_IDLE;
                     phase_in = PH_OPEN;
                     bit_in   = '0;
                  end else begin
                     bit_in   = bit_ff + BIT_W'(1);
                     phase_in = PH_OPEN;
                  end
               end
            end else begin
               step_in  = ST_IDLE;
               phase_in = PH_OPEN;
               tick_in  = '0;
               bit_in   = '0;
            end
         end
         default: begin
            step_in  = ST_IDLE;
            phase_in = PH_OPEN;
            tick_in  = '0;
            bit_in   = '0;
         end
      endcase
   end

   assign res.bus_drive   = drive;
   assign res.busy_res    = (cur_step != ST_IDLE);
   assign res.done_res    = done;
   assign res.temperature = temp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ST_IDLE;
         phase_ff  <= PH_OPEN;
         tick_ff   <= '0;
         bit_ff    <= '0;
         cmd_ff    <= '0;
         rshift_ff <= '0;
         temp_ff   <= '0;
      end else if (step_en) begin
         step_ff   <= step_in;
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         cmd_ff    <= cmd_in;
         rshift_ff <= rshift_in;
         temp_ff   <= temp_in;
      end
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (step_en && res.done_res) |-> res.busy_res)
      else $error("done reported outside a running sequence");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && res.done_res) |=> (step_ff == ST_IDLE))
      else $error("sequencer did not return to idle after done");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> ($stable(step_ff) && $stable(tick_ff) && $stable(temp_ff)))
      else $error("sequencer state moved without a transaction");

   a_idle_release: assert property (@(posedge clock) disable iff (reset)
      (step_en && !res.busy_res) |-> (res.bus_drive == DRIVE_RELEASE))
      else $error("bus driven while idle");

endmodule

>>> sv/onewire_temperature_reader.sv
// Channel  Direction  Transaction payload
// req      in         tdata[0] start_req, tdata[1] line_level
// rsp      out        tdata[1:0] bus_drive, [2] busy_res, [3] done_res, [19:4] temperature
// csr      in         APB writes and reads of the seven tick-count registers
//
// One transaction per clock cycle while req_tready is high: each req transaction is one
// bus tick, yields one rsp transaction and advances the sequencer state registers.
// The rsp output register lets a new req transaction in while a result is still held.
// req_tready drops only while a result is held and rsp_tready is low.
// Reset is synchronous; it loads the register defaults and idles the sequencer.
module onewire_temperature_reader #(
   parameter int READ_BITS = 16,
   parameter int COUNTER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // start_req, line_level

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // bus_drive[1:0], busy_res, done_res, temperature[15:0]

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import owtr_pkg::*;

   cfg_type              cfg_ff;
   logic [REG_IDX_W-1:0] csr_index;
   logic                 csr_write;

   logic    req_accept;
   rsp_type seq_res;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write && (32'(csr_index) < NUM_REGS)) begin
         cfg_ff[csr_index] <= csr_pwdata[DUR_W-1:0];
      end
   end

   always_comb begin
      if (32'(csr_index) < NUM_REGS) begin
         csr_prdata = 32'(cfg_ff[csr_index]);
      end else begin
         csr_prdata = '0;
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   owtr_seq #(
      .READ_BITS(READ_BITS),
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .step_en(req_accept),
      .start_req(req_tdata[0]),
      .line_level(req_tdata[1]),
      .cfg(cfg_ff),
      .res(seq_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= seq_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule
